FILE: rtl/core/midi_note_event_serializer_core_defines.svh
// Assertion macros for the MIDI note event serializer core.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef MIDI_NOTE_EVENT_SERIALIZER_CORE_DEFINES_SVH
`define MIDI_NOTE_EVENT_SERIALIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MNES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MNES_ASSERT_NEVER(lbl, cond, msg) \
  `MNES_ASSERT(lbl, !(cond), msg)
`else
`define MNES_ASSERT(lbl, prop, msg)
`define MNES_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/mnes_pkg.sv
// Shared types and constants of the MIDI note event serializer core.
// Depends on nothing.
package mnes_pkg;

  localparam int TICKS_W   = 28;
  localparam int PROD_W    = 33;
  localparam int STEP_BITS = 5;
  localparam int DIV_STEPS = 7;
  localparam int DVD_W     = STEP_BITS * DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [TICKS_W-1:0] VLQ_MAX    = 28'h0FFFFFFF;
  localparam logic [7:0]         STATUS_ON  = 8'b10010000;
  localparam logic [7:0]         STATUS_OFF = 8'b10000000;
  localparam logic [14:0]        TPQ_RESET  = 15'd256;

  // Register index, taken from byte address bit 2.
  localparam logic REG_TICKS_PER_QUARTER = 1'b0;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  // One classified event waiting to be serialized.
  typedef struct packed {
    logic [TICKS_W-1:0] ticks;
    logic [1:0]         top;     // index of the highest nonzero 7-bit group
    logic [7:0]         status;
    logic [6:0]         pitch;
    logic [6:0]         velocity;
  } mnes_event_t;

endpackage

FILE: rtl/core/mnes_event_if.sv
// Note event channel: valid/ready handshake with the event fields.
// Depends on nothing.
interface mnes_event_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  channel;
  logic [6:0]  pitch;
  logic [6:0]  velocity;
  logic [15:0] delta_num;
  logic [15:0] delta_den;

  modport source (output valid, func, channel, pitch, velocity, delta_num, delta_den,
                  input ready);
  modport sink (input valid, func, channel, pitch, velocity, delta_num, delta_den,
                output ready);
endinterface

FILE: rtl/core/mnes_byte_if.sv
// Byte stream channel: valid/ready handshake with one track byte and a last flag.
// Depends on nothing.
interface mnes_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

FILE: rtl/core/mnes_front.sv
// Front end: accepts note events, scales the delta time and divides it to ticks.
// Depends on mnes_pkg and mnes_event_if.
module mnes_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [14:0]         ticks_per_quarter,
  mnes_event_if.sink          note,
  output mnes_pkg::mnes_event_t evt,
  output logic                evt_valid,
  input  logic                evt_ready
);
  import mnes_pkg::*;

  logic              s1_valid;
  logic [PROD_W-1:0] s1_prod;
  logic [15:0]       s1_den;
  logic [7:0]        s1_status;
  logic [6:0]        s1_pitch;
  logic [6:0]        s1_velocity;
  logic [30:0]       mult;

  div_state_t         div_state, div_state_next;
  logic               div_load;
  logic [DVD_W-1:0]   dvd, dvd_next;
  logic [DVD_W-1:0]   quo, quo_next;
  logic [15:0]        rem, rem_next;
  logic [15:0]        den;
  logic [DIV_CNT_W-1:0] cnt;
  logic [7:0]         d_status;
  logic [6:0]         d_pitch;
  logic [6:0]         d_velocity;
  logic [TICKS_W-1:0] ticks;

  assign div_load   = s1_valid && (div_state == DIV_IDLE ||
                                   (div_state == DIV_DONE && evt_ready));
  assign note.ready = !rst && (!s1_valid || div_load);
  assign mult       = 31'(note.delta_num) * 31'(ticks_per_quarter);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (note.valid && note.ready) begin
      s1_valid <= 1'b1;
    end else if (div_load) begin
      s1_valid <= 1'b0;
    end
    if (note.valid && note.ready) begin
      s1_prod     <= {mult, 2'b00};
      s1_den      <= (note.delta_den == 16'd0) ? 16'd1 : note.delta_den;
      s1_status   <= (note.func ? STATUS_ON : STATUS_OFF) | {4'b0000, note.channel};
      s1_pitch    <= note.pitch;
      s1_velocity <= note.velocity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_IDLE;
    end else begin
      div_state <= div_state_next;
    end
  end

  always_comb begin
    div_state_next = div_state;
    case (div_state)
      DIV_IDLE: begin
        if (s1_valid) div_state_next = DIV_RUN;
      end
      DIV_RUN: begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) div_state_next = DIV_DONE;
      end
      DIV_DONE: begin
        if (evt_ready) div_state_next = s1_valid ? DIV_RUN : DIV_IDLE;
      end
      default: div_state_next = DIV_IDLE;
    endcase
  end

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    logic [16:0] trial;
    logic        qb;
    dvd_next = dvd;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial    = {rem_next, dvd_next[DVD_W-1]};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      qb       = (trial >= {1'b0, den});
      if (qb) trial = trial - {1'b0, den};
      rem_next = trial[15:0];
      quo_next = {quo_next[DVD_W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      dvd        <= {{(DVD_W - PROD_W){1'b0}}, s1_prod};
      quo        <= '0;
      rem        <= '0;
      cnt        <= '0;
      den        <= s1_den;
      d_status   <= s1_status;
      d_pitch    <= s1_pitch;
      d_velocity <= s1_velocity;
    end else if (div_state == DIV_RUN) begin
      dvd <= dvd_next;
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt + DIV_CNT_W'(1);
    end
  end

  assign ticks = (quo[DVD_W-1:TICKS_W] != '0) ? VLQ_MAX : quo[TICKS_W-1:0];

  always_comb begin
    evt.ticks    = ticks;
    evt.status   = d_status;
    evt.pitch    = d_pitch;
    evt.velocity = d_velocity;
    if (ticks[27:21] != 7'd0)      evt.top = 2'd3;
    else if (ticks[20:14] != 7'd0) evt.top = 2'd2;
    else if (ticks[13:7] != 7'd0)  evt.top = 2'd1;
    else                           evt.top = 2'd0;
  end

  assign evt_valid = (div_state == DIV_DONE);

endmodule

FILE: rtl/core/mnes_queue.sv
// Small event queue between the front end and the byte serializer.
// Depends on mnes_pkg.
module mnes_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  mnes_pkg::mnes_event_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output mnes_pkg::mnes_event_t pop_data
);
  import mnes_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mnes_event_t      entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
    if (do_push) entries[wptr] <= push_data;
  end

endmodule

FILE: rtl/core/mnes_back.sv
// Back end: turns one queued event into its track bytes, one byte per cycle while the stream is ready.
// Depends on mnes_pkg and mnes_byte_if.
module mnes_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  evt_valid,
  output logic                  evt_ready,
  input  mnes_pkg::mnes_event_t evt,
  mnes_byte_if.source           stream
);
  import mnes_pkg::*;

  mnes_event_t cur;
  logic        cur_valid;
  logic [2:0]  k;
  logic [2:0]  top3;
  logic [1:0]  g;
  logic [6:0]  grp;
  logic [7:0]  byte_sel;
  logic        last_byte;
  logic        can_load;
  logic        ov, ol;
  logic [7:0]  ob;

  assign top3      = {1'b0, cur.top};
  assign can_load  = !ov || stream.ready;
  assign last_byte = cur_valid && (k == top3 + 3'd3);
  assign evt_ready = !cur_valid || (can_load && last_byte);
  assign g         = cur.top - k[1:0];

  always_comb begin
    case (g)
      2'd3:    grp = cur.ticks[27:21];
      2'd2:    grp = cur.ticks[20:14];
      2'd1:    grp = cur.ticks[13:7];
      default: grp = cur.ticks[6:0];
    endcase
    // Delta groups first, continuation bit on all but the lowest group.
    if (k <= top3)               byte_sel = {(g != 2'd0), grp};
    else if (k == top3 + 3'd1)   byte_sel = cur.status;
    else if (k == top3 + 3'd2)   byte_sel = {1'b0, cur.pitch};
    else                         byte_sel = {1'b0, cur.velocity};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov        <= 1'b0;
      cur_valid <= 1'b0;
    end else begin
      if (can_load) ov <= cur_valid;
      if (evt_valid && evt_ready) cur_valid <= 1'b1;
      else if (can_load && last_byte) cur_valid <= 1'b0;
    end
    if (can_load && cur_valid) begin
      ob <= byte_sel;
      ol <= last_byte;
    end
    // A new event restarts the byte index, even when its predecessor's last
    // byte leaves in the same cycle.
    if (evt_valid && evt_ready) begin
      cur <= evt;
      k   <= 3'd0;
    end else if (can_load && cur_valid) begin
      k <= k + 3'd1;
    end
  end

  assign stream.valid    = ov;
  assign stream.out_byte = ob;
  assign stream.last     = ol;

endmodule

FILE: rtl/core/midi_note_event_serializer_core.sv
// Top level of the MIDI note event serializer core.
// Depends on mnes_pkg, the channel interfaces, mnes_front, mnes_queue and mnes_back.
//
// The core takes one note-on or note-off event per word on the note channel and
// emits its Standard MIDI File track bytes on the stream channel: the delta time
// as a variable-length quantity (every 7-bit group from the highest nonzero one
// down, continuation bit set on all but the last), then the status byte, the
// pitch and the velocity, with last set on the velocity byte. The delta time is
// delta_num/delta_den whole notes, converted to floor(num*division*4/den) ticks
// and saturated to 0x0FFFFFFF; a zero denominator counts as one. The front end
// multiplies the delta as it accepts an event into its input register, then runs
// a radix-32 restoring divider and holds the result in a done state until the
// queue takes it; the next event can already wait in the input register while
// the divider works. The back end gives one byte per cycle while the stream is
// ready, four to seven per event, and a small event queue lets the two sides
// stall independently. The sustained event rate is bounded by the divider and
// by the bytes of each event. The division register sits at byte address 0 of
// the APB port and resets to 256; it may only be written while the core is
// idle. There is no clearing pass after reset.
`include "midi_note_event_serializer_core_defines.svh"

module midi_note_event_serializer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  mnes_event_if.sink  note,
  mnes_byte_if.source stream,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mnes_pkg::*;

  logic [14:0] ticks_per_quarter;
  logic        cfg_write;

  mnes_event_t front_evt;
  logic        front_valid, front_ready;
  mnes_event_t back_evt;
  logic        back_valid, back_ready;

  // Configuration: the write lands at the access cycle; reads are combinational.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == REG_TICKS_PER_QUARTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_quarter <= TPQ_RESET;
    end else if (cfg_write) begin
      ticks_per_quarter <= pwdata[14:0];
    end
  end

  assign prdata = (paddr[2] == REG_TICKS_PER_QUARTER) ? {17'd0, ticks_per_quarter} : 32'd0;

  mnes_front u_front (
    .clk               (clk),
    .rst               (rst),
    .ticks_per_quarter (ticks_per_quarter),
    .note              (note),
    .evt               (front_evt),
    .evt_valid         (front_valid),
    .evt_ready         (front_ready)
  );

  mnes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_evt),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_evt)
  );

  mnes_back u_back (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (back_valid),
    .evt_ready (back_ready),
    .evt       (back_evt),
    .stream    (stream)
  );

  // A finished division must hold its result until the queue takes it.
  `MNES_ASSERT(front_hold_a,
    (front_valid && !front_ready) |=> (front_valid && $stable(front_evt)),
    "divider result changed while stalled")
  // A delta byte with the continuation bit set can never close an event.
  `MNES_ASSERT_NEVER(cont_last_a,
    stream.valid && stream.last && stream.out_byte[7],
    "continuation byte flagged last")
  // A highest group index of three must point at a nonzero top group.
  `MNES_ASSERT_NEVER(top_group_a,
    front_valid && (front_evt.top == 2'd3) && (front_evt.ticks[27:21] == 7'd0),
    "top group index wrong")

endmodule
